// ===== rtl/iil_pkg.sv =====
`default_nettype none

package iil_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = 6;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   localparam logic [1:0] OP_GET  = 2'd0;
   localparam logic [1:0] OP_HEAD = 2'd1;
   localparam logic [1:0] OP_TAIL = 2'd2;
   localparam logic [1:0] OP_AT   = 2'd3;

   localparam logic [DATA_W-1:0] MISS_VALUE = '1;

   typedef struct packed {
      logic shift;
      logic load;
      logic sel;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/iil_cell.sv =====
`default_nettype none

module iil_cell
   import iil_pkg::*;
(
   input  wire logic                clock,
   input  wire cell_ctrl_type       ctrl,
   input  wire logic [DATA_W-1:0]   prev_data,
   input  wire logic [DATA_W-1:0]   new_data,
   output logic      [DATA_W-1:0]   data,
   output logic      [DATA_W-1:0]   read_data
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.load) begin
         data_in = new_data;
      end else if (ctrl.shift) begin
         data_in = prev_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   // Only the selected cell drives its entry; the others give zero to the OR.
   assign read_data = ctrl.sel ? data_ff : '0;

endmodule

`default_nettype wire

// ===== rtl/indexed_insert_list.sv =====
// Channel   | Ports                                          | Handshake
// request   | req_opcode, req_position, req_item_value       | start && !busy
// response  | rsp_read_value, rsp_hit, rsp_accepted,         | rsp_valid, one cycle
//           | rsp_list_length                                |
//
// One item per cycle: the row of entry cells shifts in parallel on an insert, and
// a get selects one cell through an OR of masked cell outputs.
// The response appears in the cycle after the item is accepted; busy stays low.
// Synchronous reset empties the list; cell contents are not cleared.
// The receiver cannot stall the response, so no output buffering is needed.
`default_nettype none

module indexed_insert_list
   import iil_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [IDX_W-1:0]   req_position,
   input  wire logic [DATA_W-1:0]  req_item_value,
   output logic                    rsp_valid,
   output logic [DATA_W-1:0]       rsp_read_value,
   output logic                    rsp_hit,
   output logic                    rsp_accepted,
   output logic [CNT_W-1:0]        rsp_list_length
);

   logic              take;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [CNT_W-1:0]  ins_pos;
   logic              ins_ok;
   logic              get_hit;
   logic [DATA_W-1:0] get_data;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [DATA_W-1:0] rsp_value_ff;
   logic [DATA_W-1:0] rsp_value_in;
   logic              rsp_hit_ff;
   logic              rsp_hit_in;
   logic              rsp_acc_ff;
   logic              rsp_acc_in;
   logic [CNT_W-1:0]  rsp_len_ff;
   logic [CNT_W-1:0]  rsp_len_in;

   cell_ctrl_type     ctrl [CAPACITY];
   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [DATA_W-1:0] cell_read [CAPACITY];

   assign busy = 1'b0;
   assign take = start && !busy;

   always_comb begin
      ins_pos = {{(CNT_W-IDX_W){1'b0}}, req_position};
      case (req_opcode)
         OP_HEAD: ins_pos = '0;
         OP_TAIL: ins_pos = count_ff;
         default: ins_pos = {{(CNT_W-IDX_W){1'b0}}, req_position};
      endcase
   end

   assign ins_ok  = take && (req_opcode != OP_GET) &&
                    (count_ff < CNT_W'(CAPACITY)) && (ins_pos <= count_ff);
   assign get_hit = (req_opcode == OP_GET) &&
                    ({{(CNT_W-IDX_W){1'b0}}, req_position} < count_ff);

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         assign ctrl[g].shift = ins_ok && (CNT_W'(g) > ins_pos);
         assign ctrl[g].load  = ins_ok && (CNT_W'(g) == ins_pos);
         assign ctrl[g].sel   = ({{(CNT_W-IDX_W){1'b0}}, req_position} == CNT_W'(g));

         if (g == 0) begin : g_first
            iil_cell u_cell (
               .clock     (clock),
               .ctrl      (ctrl[g]),
               .prev_data (req_item_value),
               .new_data  (req_item_value),
               .data      (cell_data[g]),
               .read_data (cell_read[g])
            );
         end else begin : g_rest
            iil_cell u_cell (
               .clock     (clock),
               .ctrl      (ctrl[g]),
               .prev_data (cell_data[g-1]),
               .new_data  (req_item_value),
               .data      (cell_data[g]),
               .read_data (cell_read[g])
            );
         end
      end
   endgenerate

   always_comb begin
      get_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         get_data = get_data | cell_read[i];
      end
   end

   always_comb begin
      count_in     = count_ff;
      rsp_valid_in = take;
      rsp_value_in = rsp_value_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_len_in   = rsp_len_ff;
      if (ins_ok) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (take) begin
         rsp_value_in = get_hit ? get_data : MISS_VALUE;
         rsp_hit_in   = get_hit;
         rsp_acc_in   = ins_ok;
         rsp_len_in   = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_len_ff   <= rsp_len_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_accepted    = rsp_acc_ff;
   assign rsp_list_length = rsp_len_ff;

endmodule

`default_nettype wire

// ===== rtl/iil_checker.sv =====
`default_nettype none

module iil_checker
   import iil_pkg::*;
(
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               start,
   input wire logic               busy,
   input wire logic [1:0]         req_opcode,
   input wire logic [IDX_W-1:0]   req_position,
   input wire logic [DATA_W-1:0]  req_item_value,
   input wire logic               rsp_valid,
   input wire logic [DATA_W-1:0]  rsp_read_value,
   input wire logic               rsp_hit,
   input wire logic               rsp_accepted,
   input wire logic [CNT_W-1:0]   rsp_list_length
);

   // Every accepted item gets its response in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (!reset && start && !busy) |=> rsp_valid)
      else $error("accepted item produced no response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("response without an accepted item");

   a_hit_xor_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_hit && rsp_accepted))
      else $error("get hit and insert accepted in one response");

   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_read_value == MISS_VALUE))
      else $error("miss or insert response without all-ones value");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_list_length <= CNT_W'(CAPACITY)) &&
                    (!rsp_accepted || (rsp_list_length != '0)))
      else $error("list length out of range");

endmodule

bind indexed_insert_list iil_checker u_iil_checker (.*);

`default_nettype wire

// ===== test/indexed_insert_list_checker.sv =====
`default_nettype none

module indexed_insert_list_checker
   import iil_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [IDX_W-1:0]   req_position,
   input  wire logic [DATA_W-1:0]  req_item_value,
   input  wire logic               rsp_valid,
   input  wire logic [DATA_W-1:0]  rsp_read_value,
   input  wire logic               rsp_hit,
   input  wire logic               rsp_accepted,
   input  wire logic [CNT_W-1:0]   rsp_list_length,
   output int                      mismatches,
   output int                      responses_seen,
   output int                      read_hits,
   output int                      inserts_refused,
   output int                      outstanding,
   output logic [CNT_W-1:0]        list_fill
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic              hit;
      logic              accepted;
      logic [CNT_W-1:0]  list_length;
   } list_response_type;

   logic [DATA_W-1:0] cells [CAPACITY];
   list_response_type due_responses [$];

   // Applies one operation to the shadow list and returns the response it should give.
   function automatic list_response_type apply_list_op(logic [1:0] op,
                                                       logic [IDX_W-1:0] pos,
                                                       logic [DATA_W-1:0] value);
      list_response_type r;
      int slot;
      r.read_value = MISS_VALUE;
      r.hit        = 1'b0;
      r.accepted   = 1'b0;
      if (op == OP_GET) begin
         if (pos < list_fill) begin
            r.read_value = cells[pos];
            r.hit        = 1'b1;
         end
      end else begin
         if (op == OP_HEAD)
            slot = 0;
         else if (op == OP_TAIL)
            slot = int'(list_fill);
         else
            slot = int'(pos);
         if (int'(list_fill) < CAPACITY && slot <= int'(list_fill)) begin
            for (int i = CAPACITY - 1; i > 0; i--)
               if (i > slot && i <= int'(list_fill))
                  cells[i] = cells[i-1];
            cells[slot] = value;
            list_fill   = list_fill + 1'b1;
            r.accepted  = 1'b1;
         end
      end
      r.list_length = list_fill;
      return r;
   endfunction

   // A response always belongs to an item accepted at an earlier edge, so it is
   // checked before the item accepted at this same edge is predicted.
   always @(posedge clock) begin
      list_response_type due, got, next;
      if (reset) begin
         due_responses.delete();
         list_fill       = '0;
         mismatches      = 0;
         responses_seen  = 0;
         read_hits       = 0;
         inserts_refused = 0;
      end else begin
         if (rsp_valid) begin
            got = '{rsp_read_value, rsp_hit, rsp_accepted, rsp_list_length};
            responses_seen++;
            if (due_responses.size() == 0) begin
               if (mismatches < 10)
                  $display("[%0t] unexpected response: value %h hit %b acc %b len %0d",
                           $realtime, got.read_value, got.hit, got.accepted,
                           got.list_length);
               mismatches++;
            end else begin
               due = due_responses.pop_front();
               if (got !== due) begin
                  if (mismatches < 10) begin
                     $write("[%0t] mismatch: expected value %h hit %b acc %b len %0d, ",
                            $realtime, due.read_value, due.hit, due.accepted,
                            due.list_length);
                     $display("got value %h hit %b acc %b len %0d",
                              got.read_value, got.hit, got.accepted, got.list_length);
                  end
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            next = apply_list_op(req_opcode, req_position, req_item_value);
            if (next.hit)
               read_hits++;
            if (req_opcode != OP_GET && !next.accepted)
               inserts_refused++;
            due_responses.push_back(next);
         end
      end
      outstanding = due_responses.size();
   end

endmodule

`default_nettype wire

// ===== test/indexed_insert_list_tb.sv =====
`default_nettype none

module indexed_insert_list_tb
   import iil_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_opcode;
   logic [IDX_W-1:0]   req_position;
   logic [DATA_W-1:0]  req_item_value;
   logic               rsp_valid;
   logic [DATA_W-1:0]  rsp_read_value;
   logic               rsp_hit;
   logic               rsp_accepted;
   logic [CNT_W-1:0]   rsp_list_length;

   int                 mismatches;
   int                 responses_seen;
   int                 read_hits;
   int                 inserts_refused;
   int                 outstanding;
   logic [CNT_W-1:0]   list_fill;

   int                 sender_idle_pct;
   int                 items_sent;

   indexed_insert_list dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (rsp_read_value),
      .rsp_hit         (rsp_hit),
      .rsp_accepted    (rsp_accepted),
      .rsp_list_length (rsp_list_length)
   );

   indexed_insert_list_checker list_check (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_read_value  (rsp_read_value),
      .rsp_hit         (rsp_hit),
      .rsp_accepted    (rsp_accepted),
      .rsp_list_length (rsp_list_length),
      .mismatches      (mismatches),
      .responses_seen  (responses_seen),
      .read_hits       (read_hits),
      .inserts_refused (inserts_refused),
      .outstanding     (outstanding),
      .list_fill       (list_fill)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles", CYCLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send_item(logic [1:0] op, logic [IDX_W-1:0] pos, logic [DATA_W-1:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start          <= 1'b1;
      req_opcode     <= op;
      req_position   <= pos;
      req_item_value <= value;
      do @(posedge clock); while (busy);
      items_sent++;
      @(negedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_value();
      logic [DATA_W-1:0] v;
      v = $urandom();
      if ($urandom_range(7) == 0)
         case ($urandom_range(3))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = '1;
            default: v = '0;
         endcase
      return v;
   endfunction

   // Positions mostly stay within the current length so reads hit and inserts land;
   // the rest span the whole field.
   task automatic send_random_item(int insert_pct);
      logic [1:0]       op;
      logic [IDX_W-1:0] pos;
      int               len;
      len = int'(list_fill);
      pos = IDX_W'($urandom_range(63));
      if ($urandom_range(99) < insert_pct) begin
         case ($urandom_range(2))
            0: op = OP_HEAD;
            1: op = OP_TAIL;
            default: op = OP_AT;
         endcase
         if (op == OP_AT && $urandom_range(9) < 8)
            pos = IDX_W'($urandom_range(len > 63 ? 63 : len));
      end else begin
         op = OP_GET;
         if (len > 0 && $urandom_range(9) < 8)
            pos = IDX_W'($urandom_range(len - 1));
      end
      send_item(op, pos, pick_value());
   endtask

   initial begin
      int idle_by_phase [4];
      int insert_by_phase [4];
      idle_by_phase   = '{0, 81, 0, 34};
      insert_by_phase = '{15, 15, 12, 30};
      reset           = 1'b1;
      start           = 1'b0;
      req_opcode      = OP_GET;
      req_position    = '0;
      req_item_value  = '0;
      sender_idle_pct = 0;
      items_sent      = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Empty list: reads miss and an insert past the length is refused.
      send_item(OP_GET,  6'd0,  32'h0);
      send_item(OP_GET,  6'd63, 32'h0);
      send_item(OP_AT,   6'd1,  32'h5);
      // Insert before index equal to the length appends.
      send_item(OP_AT,   6'd0,  32'h7fff_ffff);
      send_item(OP_HEAD, 6'd0,  32'h8000_0000);
      send_item(OP_TAIL, 6'd0,  32'hffff_ffff);
      send_item(OP_TAIL, 6'd63, 32'h0);
      send_item(OP_AT,   6'd2,  32'h1234_5678);
      send_item(OP_AT,   6'd5,  32'h0000_0001);
      send_item(OP_AT,   6'd63, 32'hffff_ffff);
      send_item(OP_HEAD, 6'd63, 32'haaaa_5555);
      for (int i = 0; i <= 7; i++)
         send_item(OP_GET, IDX_W'(i), 32'hdead_beef);
      send_item(OP_GET,  6'd63, 32'h0);

      // Random part; the list only grows, so later phases spend time on a full store.
      for (int p = 0; p < 4; p++) begin
         sender_idle_pct = idle_by_phase[p];
         for (int n = 0; n < 182; n++)
            send_random_item(insert_by_phase[p]);
      end
      start <= 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d items and checked %0d responses: %0d reads hit, %0d inserts refused.",
               items_sent, responses_seen, read_hits, inserts_refused);
      $display("The list ended with %0d of %0d entries.", list_fill, CAPACITY);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/iil_pkg.sv
rtl/iil_cell.sv
rtl/indexed_insert_list.sv
rtl/iil_checker.sv
test/indexed_insert_list_checker.sv
test/indexed_insert_list_tb.sv
